/* hw/rtl/lrs_pkg.sv */
`timescale 1ns / 1ps
package lrs_pkg;
    localparam int ELEM_COUNT = 1024;
    localparam int IDX_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int SUM_W      = 64;
    localparam int OPND_W     = 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ASSIGN = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;
endpackage

/* hw/rtl/lrs_elem_ram.sv */
`timescale 1ns / 1ps
module lrs_elem_ram (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [lrs_pkg::IDX_W-1:0]     waddr,
    input  logic [lrs_pkg::SUM_W-1:0]     wdata,
    input  logic                          re,
    input  logic [lrs_pkg::IDX_W-1:0]     raddr,
    output logic [lrs_pkg::SUM_W-1:0]     rdata
);
    logic [lrs_pkg::SUM_W-1:0] mem [lrs_pkg::ELEM_COUNT];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* hw/rtl/lazy_range_add_set_sum_tree.sv */
`timescale 1ns / 1ps
// Range add / range assign / range sum over 1024 signed 64-bit elements.
// Elements live in one single-port-write, registered-read memory and are
// swept one per cycle through a shared 64-bit adder. An update passes
// through SWEEP and DRAIN back to IDLE; a query passes through SWEEP, DRAIN and
// FINISH, where it waits for m_tready while an earlier result still sits in
// the output register. An empty update or unused command stays in IDLE and
// an empty query goes straight to FINISH. s_tready is low while a command is
// in progress. After reset a clearing pass zeroes the store before the first
// item is taken. A query result waits in an output register until taken.
module lazy_range_add_set_sum_tree (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata,   // active_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,     // lo_index[9:0], hi_index[19:10], operand[51:20]
    input  logic [1:0]  s_tuser,     // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata      // range_sum
);
    localparam logic [lrs_pkg::IDX_W-1:0] LAST_IDX = lrs_pkg::IDX_W'(lrs_pkg::ELEM_COUNT - 1);

    lrs_pkg::state_t state_reg, state_next;
    logic [lrs_pkg::SIZE_W-1:0] size_reg;
    logic [lrs_pkg::IDX_W-1:0]  idx_reg, idx_next, hi_reg, hi_next;
    logic [lrs_pkg::IDX_W-1:0]  wa_reg;
    logic                       pend_reg;
    lrs_pkg::cmd_t              cmd_reg, cmd_next;
    logic [lrs_pkg::SUM_W-1:0]  opnd_reg, opnd_next, acc_reg, acc_next;
    logic [lrs_pkg::SUM_W-1:0]  out_reg;
    logic                       out_valid_reg;

    logic                       accept, rd_en, we;
    logic [lrs_pkg::SUM_W-1:0]  rdata, wdata, sum;
    logic [lrs_pkg::IDX_W-1:0]  in_lo, in_hi, hi_clip, waddr;
    logic [lrs_pkg::SIZE_W-1:0] n_eff;
    logic                       empty, load_out;
    lrs_pkg::cmd_t              in_cmd;

    assign in_lo  = s_tdata[9:0];
    assign in_hi  = s_tdata[19:10];
    assign in_cmd = lrs_pkg::cmd_t'(s_tuser);
    assign accept = s_tvalid && s_tready;

    // Clip the interval to the active size.
    always_comb begin
        n_eff = (size_reg > lrs_pkg::SIZE_W'(lrs_pkg::ELEM_COUNT)) ?
                lrs_pkg::SIZE_W'(lrs_pkg::ELEM_COUNT) : size_reg;
        hi_clip = in_hi;
        if ({1'b0, in_hi} > n_eff - 1'b1) begin
            hi_clip = lrs_pkg::IDX_W'(n_eff - 1'b1);
        end
        empty = (n_eff == '0) || (in_lo > hi_clip);
    end

    // Shared adder: element update or running sum.
    assign sum = (cmd_reg == lrs_pkg::CMD_QUERY) ? acc_reg + rdata : rdata + opnd_reg;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        hi_next    = hi_reg;
        cmd_next   = cmd_reg;
        opnd_next  = opnd_reg;
        acc_next   = acc_reg;
        case (state_reg)
            lrs_pkg::ST_CLEAR: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = lrs_pkg::ST_IDLE;
                end
            end
            lrs_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_next  = in_cmd;
                    opnd_next = {{(lrs_pkg::SUM_W-lrs_pkg::OPND_W){s_tdata[51]}},
                                 s_tdata[51:20]};
                    idx_next  = in_lo;
                    hi_next   = hi_clip;
                    acc_next  = '0;
                    if (in_cmd == lrs_pkg::CMD_QUERY && empty) begin
                        state_next = lrs_pkg::ST_FINISH;
                    end else if (in_cmd != lrs_pkg::CMD_NONE && !empty) begin
                        state_next = lrs_pkg::ST_SWEEP;
                    end
                end
            end
            lrs_pkg::ST_SWEEP: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == hi_reg) begin
                    state_next = lrs_pkg::ST_DRAIN;
                end
            end
            lrs_pkg::ST_DRAIN: begin
                state_next = (cmd_reg == lrs_pkg::CMD_QUERY) ? lrs_pkg::ST_FINISH
                                                            : lrs_pkg::ST_IDLE;
            end
            lrs_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = lrs_pkg::ST_IDLE;
                end
            end
            default: state_next = lrs_pkg::ST_IDLE;
        endcase
        if (pend_reg && cmd_reg == lrs_pkg::CMD_QUERY) begin
            acc_next = sum;
        end
    end

    always_comb begin
        s_tready = (state_reg == lrs_pkg::ST_IDLE);
        rd_en    = (state_reg == lrs_pkg::ST_SWEEP);
        load_out = (state_reg == lrs_pkg::ST_FINISH) && (!out_valid_reg || m_tready);
        if (state_reg == lrs_pkg::ST_CLEAR) begin
            we    = 1'b1;
            waddr = idx_reg;
            wdata = '0;
        end else begin
            we    = pend_reg && (cmd_reg != lrs_pkg::CMD_QUERY);
            waddr = wa_reg;
            wdata = (cmd_reg == lrs_pkg::CMD_ASSIGN) ? opnd_reg : sum;
        end
    end

    lrs_elem_ram u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lrs_pkg::ST_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            size_reg      <= lrs_pkg::SIZE_W'(lrs_pkg::ELEM_COUNT);
            cmd_reg       <= lrs_pkg::CMD_NONE;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= rd_en;
            cmd_reg   <= cmd_next;
            if (cfg_wen) begin
                size_reg <= cfg_wdata;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg   <= hi_next;
        opnd_reg <= opnd_next;
        acc_reg  <= acc_next;
        wa_reg   <= idx_reg;
        if (load_out) begin
            out_reg <= acc_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_no_take_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lrs_pkg::ST_SWEEP) |-> !s_tready)
        else $error("item taken during sweep");
    a_read_follows_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> ($past(state_reg) == lrs_pkg::ST_SWEEP))
        else $error("read data without a sweep");
    a_clear_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !s_tready)
        else $error("ready before clearing pass");
endmodule
